@@ design/palindromic_tree_builder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Palindromic tree builder assertion macros
// Clocked implication checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PALINDROMIC_TREE_BUILDER_CORE_ASSERT_SVH
`define PALINDROMIC_TREE_BUILDER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// consequent holds in the same cycle as the antecedent
`define PTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptb assertion failed");
// consequent holds in the cycle after the antecedent
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptb assertion failed");
`else
`define PTB_ASSERT_NOW(label, clk, rst, ante, cons)
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/ptb_pkg.sv @@
// ----------------------------------------------------------------------------
// Palindromic tree builder package
// Sizes, command and status codes, controller operations and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int CNT_W       = NODE_W + 1;
   localparam int MAX_TEXT    = 1024;
   localparam int TEXT_AW     = $clog2(MAX_TEXT);
   localparam int POS_W       = TEXT_AW + 1;
   localparam int ALPHABET    = 26;
   localparam int LET_W       = 5;
   localparam int MAX_STRINGS = 4;
   localparam int STR_W       = 2;
   localparam int LEN_W       = 12;
   localparam int EDGE_DEPTH  = MAX_NODES * ALPHABET;
   localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
   localparam int KEY_W       = NODE_W + LET_W;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_END   = 2'd1;
   localparam logic [1:0] CMD_COUNT = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL = 2'd1;
   localparam logic [1:0] ST_TEXT_LONG  = 2'd2;
   localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_ERR_OUT, OP_ERR_FULL,
      OP_ADD_BEGIN, OP_END_BEGIN, OP_CNT_BEGIN, OP_READ_BEGIN,
      OP_WALK_RD, OP_WALK_TX, OP_WALK_STEP, OP_PAR_SET, OP_Q_SET,
      OP_EDGE_NODE, OP_FOUND, OP_FOUND_UPD, OP_CREATE, OP_LINK_WR, OP_ADD_FIN,
      OP_CP_RD, OP_CP_WR, OP_P2_RD, OP_P2_LNK, OP_P2_WR, OP_REP_RD, OP_REP_OUT
   } dp_op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] err;
      logic       walk_hit;
      logic       edge_valid;
      logic       table_full;
      logic       par_root0;
      logic       idx_last;
      logic       used_two;
   } dp_status_type;

   function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] node,
                                                    input logic [LET_W-1:0] letter);
      edge_addr = EDGE_AW'(node) * EDGE_AW'(ALPHABET) + EDGE_AW'(letter);
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      sat_add = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
   endfunction

endpackage

@@ design/ptb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Palindromic tree builder controller
// Sequences one command at a time and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ptb_pkg::dp_status_type stat,
   output ptb_pkg::dp_op_type     op,
   output logic                   busy
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_WRD, S_WTX, S_WCMP, S_ENODE, S_ECHK, S_FUPD, S_FIN,
      S_CRD, S_CWR, S_PRD, S_PLNK, S_PWR, S_RRD, S_ROUT
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      op        = ptb_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = ptb_pkg::OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            second_in = 1'b0;
            if (stat.err != ptb_pkg::ST_OK) begin
               op       = ptb_pkg::OP_ERR_OUT;
               state_in = S_IDLE;
            end else begin
               case (stat.cmd)
                  ptb_pkg::CMD_ADD: begin
                     op       = ptb_pkg::OP_ADD_BEGIN;
                     state_in = S_WRD;
                  end
                  ptb_pkg::CMD_END: begin
                     op       = ptb_pkg::OP_END_BEGIN;
                     state_in = S_RRD;
                  end
                  ptb_pkg::CMD_COUNT: begin
                     op       = ptb_pkg::OP_CNT_BEGIN;
                     state_in = stat.used_two ? S_RRD : S_CRD;
                  end
                  default: begin
                     op       = ptb_pkg::OP_READ_BEGIN;
                     state_in = S_RRD;
                  end
               endcase
            end
         end
         S_WRD: begin
            op       = ptb_pkg::OP_WALK_RD;
            state_in = S_WTX;
         end
         S_WTX: begin
            op       = ptb_pkg::OP_WALK_TX;
            state_in = S_WCMP;
         end
         S_WCMP: begin
            if (stat.walk_hit) begin
               op       = second_ff ? ptb_pkg::OP_Q_SET : ptb_pkg::OP_PAR_SET;
               state_in = S_ENODE;
            end else begin
               op       = ptb_pkg::OP_WALK_STEP;
               state_in = S_WRD;
            end
         end
         S_ENODE: begin
            op       = ptb_pkg::OP_EDGE_NODE;
            state_in = S_ECHK;
         end
         S_ECHK: begin
            if (second_ff) begin
               op       = ptb_pkg::OP_LINK_WR;
               state_in = S_FIN;
            end else if (stat.edge_valid) begin
               op       = ptb_pkg::OP_FOUND;
               state_in = S_FUPD;
            end else if (stat.table_full) begin
               op       = ptb_pkg::OP_ERR_FULL;
               state_in = S_IDLE;
            end else begin
               op        = ptb_pkg::OP_CREATE;
               second_in = 1'b1;
               state_in  = stat.par_root0 ? S_FIN : S_WRD;
            end
         end
         S_FUPD: begin
            op       = ptb_pkg::OP_FOUND_UPD;
            state_in = S_FIN;
         end
         S_FIN: begin
            op       = ptb_pkg::OP_ADD_FIN;
            state_in = S_RRD;
         end
         S_CRD: begin
            op       = ptb_pkg::OP_CP_RD;
            state_in = S_CWR;
         end
         S_CWR: begin
            op       = ptb_pkg::OP_CP_WR;
            state_in = stat.idx_last ? S_PRD : S_CRD;
         end
         S_PRD: begin
            op       = ptb_pkg::OP_P2_RD;
            state_in = S_PLNK;
         end
         S_PLNK: begin
            op       = ptb_pkg::OP_P2_LNK;
            state_in = S_PWR;
         end
         S_PWR: begin
            op       = ptb_pkg::OP_P2_WR;
            state_in = stat.idx_last ? S_RRD : S_PRD;
         end
         S_RRD: begin
            op       = ptb_pkg::OP_REP_RD;
            state_in = S_ROUT;
         end
         S_ROUT: begin
            op       = ptb_pkg::OP_REP_OUT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

@@ design/ptb_datapath.sv @@
// ----------------------------------------------------------------------------
// Palindromic tree builder datapath
// Node, edge, text and per-string count memories with the walk registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palindromic_tree_builder_core_assert.svh"

module ptb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ptb_pkg::dp_op_type                    op,
   input  logic [1:0]                            req_command,
   input  logic [ptb_pkg::LET_W-1:0]             req_letter,
   input  logic [ptb_pkg::STR_W-1:0]             req_string_index,
   input  logic [ptb_pkg::NODE_W-1:0]            req_node_index,
   input  logic [2:0]                            num_strings,
   output ptb_pkg::dp_status_type                stat,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [ptb_pkg::NODE_W-1:0]            rsp_current_node,
   output logic                                  rsp_created,
   output logic signed [ptb_pkg::LEN_W-1:0]      rsp_node_length,
   output logic [ptb_pkg::NODE_W-1:0]            rsp_link_target,
   output logic signed [ptb_pkg::CNT_W-1:0]      rsp_start_position,
   output logic [ptb_pkg::CNT_W-1:0]            rsp_occurrences,
   output logic [ptb_pkg::CNT_W-1:0]            rsp_node_total
);

   localparam int NW = ptb_pkg::NODE_W;
   localparam int CW = ptb_pkg::CNT_W;
   localparam int LW = ptb_pkg::LEN_W;
   localparam int NS = ptb_pkg::MAX_STRINGS;

   typedef logic [NS-1:0][CW-1:0] row_type;

   // request and tree state
   logic [1:0]                 cmd_ff;
   logic [ptb_pkg::LET_W-1:0]  let_ff;
   logic [ptb_pkg::STR_W-1:0]  str_ff;
   logic [NW-1:0]              ni_ff;
   logic [CW-1:0]              used_ff;
   logic [NW-1:0]              cur_ff;
   logic [ptb_pkg::POS_W-1:0]  pos_ff;
   row_type                    root_occ_ff [2];

   // walk and sequencing registers
   logic [NW-1:0]       wnode_ff, wlink_ff, par_ff, parlink_ff, cand_ff, node_ff;
   logic [NW-1:0]       rep_node_ff, idx_ff, lnk_ff;
   logic signed [LW-1:0] wlen_ff, parlen_ff, nodelen_ff;
   logic                wext_ff, made_ff, rep_ok_ff;
   logic [CW-1:0]       self_ff;

   // memories and their registered read data
   logic signed [LW-1:0]         plen_mem  [ptb_pkg::MAX_NODES];
   logic [NW-1:0]                slink_mem [ptb_pkg::MAX_NODES];
   logic [ptb_pkg::KEY_W-1:0]    key_mem   [ptb_pkg::MAX_NODES];
   logic [NW-1:0]                edge_mem  [ptb_pkg::EDGE_DEPTH];
   logic [ptb_pkg::LET_W-1:0]    text_mem  [ptb_pkg::MAX_TEXT];
   row_type                      start_mem [ptb_pkg::MAX_NODES];
   row_type                      msc_mem   [ptb_pkg::MAX_NODES];
   row_type                      occ_mem   [ptb_pkg::MAX_NODES];

   logic signed [LW-1:0]         plen_rd_ff;
   logic [NW-1:0]                slink_rd_ff, edge_rd_ff, na_q_ff, ra_q_ff;
   logic [ptb_pkg::KEY_W-1:0]    key_rd_ff;
   logic [ptb_pkg::LET_W-1:0]    text_rd_ff;
   row_type                      start_rd_ff, msc_rd_ff, occ_rd_ff;

   // output registers
   logic                 out_valid_ff;
   logic [1:0]           out_status_ff;
   logic [NW-1:0]        out_node_ff, out_link_ff;
   logic                 out_created_ff;
   logic signed [LW-1:0] out_len_ff;
   logic signed [CW-1:0] out_start_ff;
   logic [CW-1:0]        out_occ_ff, out_total_ff;

   // combinational
   logic [2:0]                  active_c;
   logic                        s_ok_c;
   logic [1:0]                  err_c;
   logic [NW-1:0]               na_c, ra_c, new_node_c;
   logic signed [LW-1:0]        plen_v, newlen_c;
   logic [NW-1:0]               slink_v;
   logic signed [LW:0]          diff_c;
   logic [ptb_pkg::EDGE_AW-1:0] edge_ra_c, edge_wa_c;
   logic                        edge_valid_c;
   logic [CW-1:0]               lane_start_c, create_start_c, msc_inc_c, base_c, sum_c;
   row_type                     create_start_row_c, create_msc_row_c;

   always_comb begin
      if (num_strings == 3'd0) begin
         active_c = 3'd1;
      end else if (num_strings > 3'(NS)) begin
         active_c = 3'(NS);
      end else begin
         active_c = num_strings;
      end
   end
   assign s_ok_c = {1'b0, str_ff} < active_c;

   always_comb begin
      case (cmd_ff)
         ptb_pkg::CMD_ADD: begin
            if ((let_ff >= ptb_pkg::LET_W'(ptb_pkg::ALPHABET)) || !s_ok_c) begin
               err_c = ptb_pkg::ST_BAD_INDEX;
            end else if (pos_ff >= ptb_pkg::POS_W'(ptb_pkg::MAX_TEXT)) begin
               err_c = ptb_pkg::ST_TEXT_LONG;
            end else begin
               err_c = ptb_pkg::ST_OK;
            end
         end
         ptb_pkg::CMD_END:   err_c = ptb_pkg::ST_OK;
         ptb_pkg::CMD_COUNT: err_c = s_ok_c ? ptb_pkg::ST_OK : ptb_pkg::ST_BAD_INDEX;
         default: begin
            err_c = (!s_ok_c || ({1'b0, ni_ff} >= used_ff)) ? ptb_pkg::ST_BAD_INDEX
                                                            : ptb_pkg::ST_OK;
         end
      endcase
   end

   // roots are fixed: imaginary root has length -1, empty root 0, both link to 0
   always_comb begin
      if (na_q_ff == NW'(0)) begin
         plen_v = -LW'(1);
      end else if (na_q_ff == NW'(1)) begin
         plen_v = '0;
      end else begin
         plen_v = plen_rd_ff;
      end
   end
   assign slink_v = (na_q_ff < NW'(2)) ? '0 : slink_rd_ff;

   // start of the mirror letter: position - length - 1, must not be negative
   assign diff_c = $signed({2'b00, pos_ff}) - $signed({plen_v[LW-1], plen_v}) - (LW+1)'(1);

   assign edge_ra_c  = ptb_pkg::edge_addr(wnode_ff, let_ff);
   assign edge_wa_c  = ptb_pkg::edge_addr(par_ff, let_ff);
   assign new_node_c = used_ff[NW-1:0];
   assign newlen_c   = parlen_ff + LW'(2);

   assign edge_valid_c = (cand_ff >= NW'(2)) && ({1'b0, cand_ff} < used_ff) &&
                         (key_rd_ff == {wnode_ff, let_ff});

   assign lane_start_c   = CW'(pos_ff) - CW'(nodelen_ff) + CW'(1);
   assign create_start_c = CW'(pos_ff) - CW'(parlen_ff) - CW'(1);
   assign msc_inc_c      = (msc_rd_ff[str_ff] == ptb_pkg::COUNT_MAX) ? msc_rd_ff[str_ff]
                                                                   : msc_rd_ff[str_ff] + CW'(1);
   assign base_c = (lnk_ff < NW'(2)) ? root_occ_ff[lnk_ff[0]][str_ff] : occ_rd_ff[str_ff];
   assign sum_c  = ptb_pkg::sat_add(base_c, self_ff);

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         create_start_row_c[k] = {CW{1'b1}};
         create_msc_row_c[k]   = '0;
      end
      create_start_row_c[str_ff] = create_start_c;
      create_msc_row_c[str_ff]   = CW'(1);
   end

   always_comb begin
      case (op)
         ptb_pkg::OP_EDGE_NODE: na_c = edge_rd_ff;
         ptb_pkg::OP_REP_RD:    na_c = rep_node_ff;
         ptb_pkg::OP_P2_RD:     na_c = idx_ff;
         default:               na_c = wnode_ff;
      endcase
   end

   always_comb begin
      case (op)
         ptb_pkg::OP_FOUND:  ra_c = cand_ff;
         ptb_pkg::OP_REP_RD: ra_c = rep_node_ff;
         ptb_pkg::OP_P2_LNK: ra_c = slink_v;
         default:            ra_c = idx_ff;
      endcase
   end

   // memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      na_q_ff     <= na_c;
      ra_q_ff     <= ra_c;
      plen_rd_ff  <= plen_mem[na_c];
      slink_rd_ff <= slink_mem[na_c];
      key_rd_ff   <= key_mem[na_c];
      edge_rd_ff  <= edge_mem[edge_ra_c];
      text_rd_ff  <= text_mem[diff_c[ptb_pkg::TEXT_AW-1:0]];
      start_rd_ff <= start_mem[ra_c];
      msc_rd_ff   <= msc_mem[ra_c];
      occ_rd_ff   <= occ_mem[ra_c];
      if (op == ptb_pkg::OP_ADD_BEGIN) begin
         text_mem[pos_ff[ptb_pkg::TEXT_AW-1:0]] <= let_ff;
      end
      if (op == ptb_pkg::OP_CREATE) begin
         plen_mem[new_node_c]  <= newlen_c;
         key_mem[new_node_c]   <= {par_ff, let_ff};
         edge_mem[edge_wa_c]   <= new_node_c;
         slink_mem[new_node_c] <= NW'(1);
         start_mem[new_node_c] <= create_start_row_c;
         msc_mem[new_node_c]   <= create_msc_row_c;
         occ_mem[new_node_c]   <= '0;
      end
      if (op == ptb_pkg::OP_LINK_WR) begin
         slink_mem[node_ff] <= edge_valid_c ? cand_ff : '0;
      end
      if (op == ptb_pkg::OP_FOUND_UPD) begin
         start_mem[node_ff][str_ff] <= lane_start_c;
         msc_mem[node_ff][str_ff]   <= msc_inc_c;
      end
      if (op == ptb_pkg::OP_CP_WR) begin
         occ_mem[idx_ff][str_ff] <= msc_rd_ff[str_ff];
      end
      if ((op == ptb_pkg::OP_P2_WR) && (lnk_ff >= NW'(2))) begin
         occ_mem[lnk_ff][str_ff] <= sum_c;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= CW'(2);
         cur_ff       <= NW'(1);
         pos_ff       <= '0;
         root_occ_ff  <= '{default: '0};
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= (op == ptb_pkg::OP_REP_OUT) || (op == ptb_pkg::OP_ERR_OUT) ||
                         (op == ptb_pkg::OP_ERR_FULL);
         case (op)
            ptb_pkg::OP_CREATE:  used_ff <= used_ff + CW'(1);
            ptb_pkg::OP_ADD_FIN: begin
               cur_ff <= node_ff;
               pos_ff <= pos_ff + ptb_pkg::POS_W'(1);
            end
            ptb_pkg::OP_END_BEGIN: begin
               cur_ff <= NW'(1);
               pos_ff <= '0;
            end
            ptb_pkg::OP_CNT_BEGIN: begin
               root_occ_ff[0][str_ff] <= '0;
               root_occ_ff[1][str_ff] <= '0;
            end
            ptb_pkg::OP_P2_WR: begin
               if (lnk_ff < NW'(2)) begin
                  root_occ_ff[lnk_ff[0]][str_ff] <= sum_c;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (op)
         ptb_pkg::OP_LATCH: begin
            cmd_ff  <= req_command;
            let_ff  <= req_letter;
            str_ff  <= req_string_index;
            ni_ff   <= req_node_index;
            made_ff <= 1'b0;
         end
         ptb_pkg::OP_ADD_BEGIN:  wnode_ff <= cur_ff;
         ptb_pkg::OP_END_BEGIN: begin
            rep_node_ff <= NW'(1);
            rep_ok_ff   <= s_ok_c;
         end
         ptb_pkg::OP_CNT_BEGIN: begin
            rep_node_ff <= cur_ff;
            rep_ok_ff   <= 1'b1;
            idx_ff      <= NW'(used_ff - CW'(1));
         end
         ptb_pkg::OP_READ_BEGIN: begin
            rep_node_ff <= ni_ff;
            rep_ok_ff   <= 1'b1;
         end
         ptb_pkg::OP_WALK_TX: begin
            wlen_ff  <= plen_v;
            wlink_ff <= slink_v;
            wext_ff  <= !diff_c[LW];
         end
         ptb_pkg::OP_WALK_STEP:  wnode_ff <= wlink_ff;
         ptb_pkg::OP_PAR_SET: begin
            par_ff     <= wnode_ff;
            parlen_ff  <= wlen_ff;
            parlink_ff <= wlink_ff;
         end
         ptb_pkg::OP_EDGE_NODE:  cand_ff <= edge_rd_ff;
         ptb_pkg::OP_FOUND: begin
            node_ff    <= cand_ff;
            nodelen_ff <= plen_v;
         end
         ptb_pkg::OP_CREATE: begin
            node_ff  <= new_node_c;
            made_ff  <= 1'b1;
            wnode_ff <= parlink_ff;
         end
         ptb_pkg::OP_ADD_FIN: begin
            rep_node_ff <= node_ff;
            rep_ok_ff   <= 1'b1;
         end
         ptb_pkg::OP_CP_WR: begin
            idx_ff <= (idx_ff == NW'(2)) ? NW'(used_ff - CW'(1)) : idx_ff - NW'(1);
         end
         ptb_pkg::OP_P2_LNK: begin
            lnk_ff  <= slink_v;
            self_ff <= occ_rd_ff[str_ff];
         end
         ptb_pkg::OP_P2_WR:      idx_ff <= idx_ff - NW'(1);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (op == ptb_pkg::OP_REP_OUT) begin
         out_status_ff  <= ptb_pkg::ST_OK;
         out_node_ff    <= rep_node_ff;
         out_created_ff <= made_ff;
         out_len_ff     <= plen_v;
         out_link_ff    <= slink_v;
         if (!rep_ok_ff || (ra_q_ff < NW'(2))) begin
            out_start_ff <= -CW'(1);
         end else begin
            out_start_ff <= start_rd_ff[str_ff];
         end
         if (!rep_ok_ff) begin
            out_occ_ff <= '0;
         end else if (ra_q_ff < NW'(2)) begin
            out_occ_ff <= root_occ_ff[ra_q_ff[0]][str_ff];
         end else begin
            out_occ_ff <= occ_rd_ff[str_ff];
         end
         out_total_ff <= used_ff;
      end else if ((op == ptb_pkg::OP_ERR_OUT) || (op == ptb_pkg::OP_ERR_FULL)) begin
         out_status_ff  <= (op == ptb_pkg::OP_ERR_FULL) ? ptb_pkg::ST_TABLE_FULL : err_c;
         out_node_ff    <= '0;
         out_created_ff <= 1'b0;
         out_len_ff     <= '0;
         out_link_ff    <= '0;
         out_start_ff   <= '0;
         out_occ_ff     <= '0;
         out_total_ff   <= used_ff;
      end
   end

   assign stat.cmd        = cmd_ff;
   assign stat.err        = err_c;
   assign stat.walk_hit   = wext_ff && (text_rd_ff == let_ff);
   assign stat.edge_valid = edge_valid_c;
   assign stat.table_full = used_ff >= CW'(ptb_pkg::MAX_NODES);
   assign stat.par_root0  = (parlen_ff == -LW'(1));
   assign stat.idx_last   = (idx_ff == NW'(2));
   assign stat.used_two   = (used_ff == CW'(2));

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_current_node   = out_node_ff;
   assign rsp_created        = out_created_ff;
   assign rsp_node_length    = out_len_ff;
   assign rsp_link_target    = out_link_ff;
   assign rsp_start_position = out_start_ff;
   assign rsp_occurrences    = out_occ_ff;
   assign rsp_node_total     = out_total_ff;

   `PTB_ASSERT_NOW(a_used_range, clock, reset, 1'b1, (used_ff >= CW'(2)) && (used_ff <= CW'(ptb_pkg::MAX_NODES)))
   `PTB_ASSERT_NOW(a_cursor_live, clock, reset, 1'b1, {1'b0, cur_ff} < used_ff)
   `PTB_ASSERT_NEXT(a_create_bump, clock, reset, op == ptb_pkg::OP_CREATE, used_ff == $past(used_ff) + CW'(1))
   `PTB_ASSERT_NEXT(a_pos_step, clock, reset, op == ptb_pkg::OP_ADD_FIN, pos_ff == $past(pos_ff) + ptb_pkg::POS_W'(1))

endmodule

@@ design/palindromic_tree_builder_core.sv @@
// ----------------------------------------------------------------------------
// Palindromic tree builder core
// Eertree over several strings with add, end, count and read commands.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low. Exactly one result
// then appears on the rsp_ ports for a single cycle under rsp_valid, and busy
// falls at the edge where that strobe rises, so the next command may be taken
// while the result is still on the ports. The receiver cannot stall, so
// capture every strobe. Bad index and text too long are reported before any
// walk starts. An add walks suffix links from the current node, each step
// being a node memory read, a text memory read and a compare; when it
// creates a node longer than one letter, a second walk finds its suffix link.
// A count makes one copy pass and then one summing pass over the nodes
// through the node table's single read port. Table full is only known once
// the first walk has ended.
// No clearing pass runs after reset: edge entries are checked against each
// node's stored parent and letter.
// Write number_of_strings only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palindromic_tree_builder_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // command channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_command,
   input  logic [ptb_pkg::LET_W-1:0]             req_letter,
   input  logic [ptb_pkg::STR_W-1:0]             req_string_index,
   input  logic [ptb_pkg::NODE_W-1:0]            req_node_index,
   // result channel
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [ptb_pkg::NODE_W-1:0]            rsp_current_node,
   output logic                                  rsp_created,
   output logic signed [ptb_pkg::LEN_W-1:0]      rsp_node_length,
   output logic [ptb_pkg::NODE_W-1:0]            rsp_link_target,
   output logic signed [ptb_pkg::CNT_W-1:0]      rsp_start_position,
   output logic [ptb_pkg::CNT_W-1:0]            rsp_occurrences,
   output logic [ptb_pkg::CNT_W-1:0]            rsp_node_total,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [2:0]                            paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   logic [2:0]             nstr_ff;
   ptb_pkg::dp_op_type     op;
   ptb_pkg::dp_status_type stat;

   // register 0 sits at byte 0; the word above it is unused
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {29'd0, nstr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         nstr_ff <= 3'd1;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         nstr_ff <= pwdata[2:0];
      end
   end

   // sequence each command as datapath operations
   ptb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .op    (op),
      .busy  (busy)
   );

   // hold the tree, walk it and drive the result registers
   ptb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .req_command        (req_command),
      .req_letter         (req_letter),
      .req_string_index   (req_string_index),
      .req_node_index     (req_node_index),
      .num_strings        (nstr_ff),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_current_node   (rsp_current_node),
      .rsp_created        (rsp_created),
      .rsp_node_length    (rsp_node_length),
      .rsp_link_target    (rsp_link_target),
      .rsp_start_position (rsp_start_position),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_node_total     (rsp_node_total)
   );

endmodule
